[design/sorted_array_priority_queue_defines.svh]
// Assertion macros shared by the checker of the sorted-array priority queue.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SAQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("saq assertion failed");

// Next-cycle implication, checked outside reset.
`define SAQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("saq assertion failed");

`endif

[design/saq_pkg.sv]
package saq_pkg;

    localparam int KEY_W          = 16;
    localparam int PAYLOAD_W      = 16;
    localparam int OCC_W          = 7;
    localparam int CAPACITY_DEFAULT = 64;

    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_DEQ   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]           operation;
        logic [KEY_W-1:0]     item_key;
        logic [PAYLOAD_W-1:0] item_payload;
    } req_t;

    typedef struct packed {
        logic [KEY_W-1:0]     out_key;
        logic [PAYLOAD_W-1:0] out_payload;
        logic                 out_valid;
        logic [OCC_W-1:0]     occupancy;
        logic                 is_empty;
        logic [1:0]           status;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

    // Broadcast from the control logic to every cell of the row.
    typedef struct packed {
        logic   enq;
        logic   deq;
        logic   descending;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

[design/saq_cell.sv]
module saq_cell (
    input  logic                clk,
    input  saq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  saq_pkg::entry_t     left_entry,
    input  logic                left_after,
    input  saq_pkg::entry_t     right_entry,
    output saq_pkg::entry_t     entry,
    output logic                after
);

    saq_pkg::entry_t entry_reg;
    saq_pkg::entry_t entry_next;

    // An empty cell counts as served after any key, so the flags along the
    // row read 0...0 1...1 and the first set flag marks the insertion point.
    always_comb
    begin
        if (!occupied)
            after = 1'b1;
        else if (ctrl.descending)
            after = entry_reg.key < ctrl.new_entry.key;
        else
            after = entry_reg.key > ctrl.new_entry.key;
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq)
        begin
            if (after)
                entry_next = left_after ? left_entry : ctrl.new_entry;
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[design/sorted_array_priority_queue.sv]
// Sorted-array priority queue built as a row of CAPACITY cells, one entry per
// cell with the front entry in the first cell. Each operation is finished in
// the cycle it is accepted: on an enqueue every cell compares its key with the
// new key and either keeps its entry, takes the new one, or takes its left
// neighbor's, and on a dequeue every cell takes its right neighbor's entry.
// The queue therefore takes one item per clock unless stalled, and the single
// compare in each cell sets that figure. The result appears in an output
// register in the cycle after acceptance; the request side stalls only while
// that register holds a result that the receiver stalls. Entries with equal
// keys leave in arrival order. No clearing pass is needed after reset: cells
// at or beyond the occupancy count are never read. Write order_descending
// through the configuration port only while no item is in flight.
module sorted_array_priority_queue #(
    parameter int CAPACITY = saq_pkg::CAPACITY_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  saq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output saq_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                desc_reg;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    saq_pkg::rsp_t       rsp_reg;
    saq_pkg::rsp_t       rsp_next;
    saq_pkg::cell_ctrl_t ctrl;
    logic                accept;
    logic                is_full;
    logic                no_entries;

    saq_pkg::entry_t     cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_after;
    logic [CAPACITY-1:0] cell_occupied;

    assign accept     = req_valid && !req_stall;
    assign req_stall  = rsp_valid_reg && rsp_stall;
    assign is_full    = count_reg == FULL_COUNT;
    assign no_entries = count_reg == '0;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        ctrl.enq = 1'b0;
        ctrl.deq = 1'b0;
        ctrl.descending = desc_reg;
        ctrl.new_entry.key = req.item_key;
        ctrl.new_entry.payload = req.item_payload;
        count_next = count_reg;
        rsp_next = '0;

        unique case (req.operation) inside
            saq_pkg::OP_ENQ:
            begin
                if (is_full)
                    rsp_next.status = saq_pkg::ST_FULL;
                else
                begin
                    ctrl.enq = accept;
                    count_next = count_reg + CW'(1);
                end
            end
            saq_pkg::OP_DEQ, saq_pkg::OP_PEEK:
            begin
                if (no_entries)
                    rsp_next.status = saq_pkg::ST_EMPTY;
                else
                begin
                    rsp_next.out_key = cell_entry[0].key;
                    rsp_next.out_payload = cell_entry[0].payload;
                    rsp_next.out_valid = 1'b1;
                    if (req.operation == saq_pkg::OP_DEQ)
                    begin
                        ctrl.deq = accept;
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            saq_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase

        rsp_next.occupancy = saq_pkg::OCC_W'(count_next);
        rsp_next.is_empty = count_next == '0;
    end

    always_comb
    begin
        if (accept)
            rsp_valid_next = 1'b1;
        else if (rsp_stall)
            rsp_valid_next = rsp_valid_reg;
        else
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            desc_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            if (cfg_valid && cfg_ready)
                desc_reg <= cfg_data;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        saq_pkg::entry_t left_entry;
        saq_pkg::entry_t right_entry;
        logic            left_after;

        assign cell_occupied[i] = IDX < count_reg;

        if (i == 0)
        begin : g_first
            assign left_entry = ctrl.new_entry;
            assign left_after = 1'b0;
        end
        else
        begin : g_inner
            assign left_entry = cell_entry[i-1];
            assign left_after = cell_after[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_body
            assign right_entry = cell_entry[i+1];
        end

        saq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (cell_occupied[i]),
            .left_entry  (left_entry),
            .left_after  (left_after),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .after       (cell_after[i])
        );
    end

endmodule

[design/saq_checker.sv]
`include "sorted_array_priority_queue_defines.svh"

module saq_checker #(
    parameter int CAPACITY = saq_pkg::CAPACITY_DEFAULT
) (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input saq_pkg::rsp_t rsp
);

    localparam logic [saq_pkg::OCC_W-1:0] FULL_OCC = saq_pkg::OCC_W'(CAPACITY);

    // A held result must not change while the receiver stalls.
    `SAQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // A returned entry only comes with a successful dequeue or peek.
    `SAQ_ASSERT_NOW(a_entry_ok, rsp_valid && rsp.out_valid, rsp.status == saq_pkg::ST_OK)

    // Without an entry the key and payload fields read zero.
    `SAQ_ASSERT_NOW(a_zero_fields, rsp_valid && !rsp.out_valid,
        rsp.out_key == '0 && rsp.out_payload == '0)

    // A full refusal reports a full store, and an empty refusal an empty one.
    `SAQ_ASSERT_NOW(a_full_occ, rsp_valid && rsp.status == saq_pkg::ST_FULL,
        rsp.occupancy == FULL_OCC)
    `SAQ_ASSERT_NOW(a_empty_flag, rsp_valid && rsp.status == saq_pkg::ST_EMPTY,
        rsp.is_empty && rsp.occupancy == '0)

endmodule

bind sorted_array_priority_queue saq_checker #(
    .CAPACITY (CAPACITY)
) u_saq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

[sim/tb_top.sv]
module tb_top;

    localparam int CAP         = saq_pkg::CAPACITY_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;

    // Tracks the stored entries in service order and the results still owed.
    class pq_scoreboard;
        saq_pkg::entry_t stored[$];
        bit              descending;
        saq_pkg::rsp_t   expected_rsps[$];
        int              mismatches;

        function void note_request(saq_pkg::req_t r);
            saq_pkg::rsp_t   exp;
            saq_pkg::entry_t ent;
            int              pos;
            exp = '0;
            exp.status = saq_pkg::ST_OK;
            case (saq_pkg::op_t'(r.operation)) inside
                saq_pkg::OP_ENQ:
                begin
                    if (stored.size() >= CAP)
                    begin
                        exp.status = saq_pkg::ST_FULL;
                    end
                    else
                    begin
                        ent.key = r.item_key;
                        ent.payload = r.item_payload;
                        // Walk back past every entry that is served after the new key,
                        // so equal keys keep their arrival order.
                        pos = stored.size();
                        while (pos > 0 && (descending ? (stored[pos-1].key < ent.key)
                                                      : (stored[pos-1].key > ent.key)))
                            pos--;
                        stored.insert(pos, ent);
                    end
                end
                saq_pkg::OP_DEQ, saq_pkg::OP_PEEK:
                begin
                    if (stored.size() == 0)
                    begin
                        exp.status = saq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        exp.out_key = stored[0].key;
                        exp.out_payload = stored[0].payload;
                        exp.out_valid = 1'b1;
                        if (saq_pkg::op_t'(r.operation) == saq_pkg::OP_DEQ)
                            void'(stored.pop_front());
                    end
                end
                default:
                begin
                    stored.delete();
                end
            endcase
            exp.occupancy = saq_pkg::OCC_W'(stored.size());
            exp.is_empty = (stored.size() == 0);
            expected_rsps.push_back(exp);
        endfunction

        function void check_response(saq_pkg::rsp_t got);
            saq_pkg::rsp_t exp;
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result with nothing outstanding: %p", got);
                return;
            end
            exp = expected_rsps.pop_front();
            if (got.out_key !== exp.out_key || got.out_payload !== exp.out_payload ||
                got.out_valid !== exp.out_valid || got.occupancy !== exp.occupancy ||
                got.is_empty !== exp.is_empty || got.status !== exp.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display({"result mismatch: expected key %h payload %h valid %b",
                              " occ %0d empty %b status %0d"},
                             exp.out_key, exp.out_payload, exp.out_valid, exp.occupancy,
                             exp.is_empty, exp.status);
                    $display({"                 actual   key %h payload %h valid %b",
                              " occ %0d empty %b status %0d"},
                             got.out_key, got.out_payload, got.out_valid, got.occupancy,
                             got.is_empty, got.status);
                end
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    saq_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_stall;
    saq_pkg::rsp_t rsp;
    logic          cfg_valid;
    logic          cfg_ready;
    logic          cfg_data;

    pq_scoreboard book;
    bit           idle_on;
    int           stall_left;
    int           cycle_count;

    sorted_array_priority_queue #(
        .CAPACITY(CAP)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[sorted_array_priority_queue] ERROR");
            $finish;
        end
    end

    // Result side: check every accepted item and stall in random bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
                book.check_response(rsp);
            if (stall_left != 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 8);
            rsp_stall <= (stall_left != 0);
        end
    end

    // Presents one item and returns at the edge where it is accepted. Valid is left
    // high so that a following item can go out back to back.
    task automatic push_op(input saq_pkg::op_t op, input logic [15:0] key,
                           input logic [15:0] pay);
        saq_pkg::req_t item;
        int            gap;
        item.operation = op;
        item.item_key = key;
        item.item_payload = pay;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        book.note_request(item);
    endtask

    task automatic write_order(input bit desc);
        req_valid <= 1'b0;
        while (book.expected_rsps.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= desc;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
        book.descending = desc;
    endtask

    task automatic run_segment(input int profile, input int count);
        saq_pkg::op_t op;
        int           roll;
        int           pick;
        logic [15:0]  key;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (profile == 0)
                op = (roll < 80) ? saq_pkg::OP_ENQ :
                     (roll < 90) ? saq_pkg::OP_DEQ : saq_pkg::OP_PEEK;
            else if (profile == 1)
                op = (roll < 25) ? saq_pkg::OP_ENQ :
                     (roll < 80) ? saq_pkg::OP_DEQ : saq_pkg::OP_PEEK;
            else
                op = (roll < 47) ? saq_pkg::OP_ENQ : (roll < 80) ? saq_pkg::OP_DEQ :
                     (roll < 97) ? saq_pkg::OP_PEEK : saq_pkg::OP_CLEAR;
            // A narrow key range produces many ties, which checks the arrival order.
            pick = $urandom_range(0, 9);
            if (pick < 3)
                key = 16'($urandom_range(0, 3));
            else if (pick == 3)
                key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else
                key = 16'($urandom_range(0, 16'hFFFF));
            push_op(op, key, 16'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    initial
    begin
        book = new();
        idle_on = 1'b1;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        rsp_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest key first: empty store, key extremes, ties, clear.
        push_op(saq_pkg::OP_PEEK, 16'hFFFF, 16'hFFFF);
        push_op(saq_pkg::OP_DEQ, 16'h0000, 16'h0000);
        push_op(saq_pkg::OP_ENQ, 16'h8000, 16'h0001);
        push_op(saq_pkg::OP_ENQ, 16'hFFFF, 16'h0000);
        push_op(saq_pkg::OP_ENQ, 16'h0000, 16'hFFFF);
        push_op(saq_pkg::OP_ENQ, 16'h8000, 16'h0002);
        push_op(saq_pkg::OP_ENQ, 16'h8000, 16'h0003);
        push_op(saq_pkg::OP_PEEK, 16'h0000, 16'h0000);
        repeat (5) push_op(saq_pkg::OP_DEQ, 16'h0000, 16'h0000);
        push_op(saq_pkg::OP_DEQ, 16'h0000, 16'h0000);
        push_op(saq_pkg::OP_ENQ, 16'h1234, 16'h5678);
        push_op(saq_pkg::OP_CLEAR, 16'h0000, 16'h0000);
        push_op(saq_pkg::OP_PEEK, 16'h0000, 16'h0000);

        // Largest key first.
        write_order(1'b1);
        push_op(saq_pkg::OP_ENQ, 16'h0000, 16'h00AA);
        push_op(saq_pkg::OP_ENQ, 16'hFFFF, 16'h00BB);
        push_op(saq_pkg::OP_ENQ, 16'hFFFF, 16'h00CC);
        push_op(saq_pkg::OP_PEEK, 16'h0000, 16'h0000);
        repeat (3) push_op(saq_pkg::OP_DEQ, 16'h0000, 16'h0000);
        push_op(saq_pkg::OP_CLEAR, 16'h0000, 16'h0000);
        write_order(1'b0);

        for (int seg = 0; seg < 14; seg++)
        begin
            idle_on = (seg < 12) && (seg % 5 != 2);
            // The stored entries are sorted under one order only, so the store is
            // emptied before the order is changed.
            if (seg % 4 == 3)
            begin
                push_op(saq_pkg::OP_CLEAR, 16'($urandom_range(0, 16'hFFFF)), 16'h0000);
                write_order(!book.descending);
            end
            run_segment(seg % 3, 102);
        end

        req_valid <= 1'b0;
        while (book.expected_rsps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (book.mismatches == 0 && book.expected_rsps.size() == 0)
            $display("[sorted_array_priority_queue] OK");
        else
            $display("[sorted_array_priority_queue] ERROR");
        $finish;
    end

endmodule
